@@ sv/cac_pkg.sv @@
// Package for the calendar age calculator: shared widths, unit codes, structs
// and the small calendar tables. No dependencies.
package cac_pkg;

	localparam int unsigned CMD_W    = 3;
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MON_W    = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned CLOCK_W  = 17;
	localparam int unsigned AGE_W    = 39;
	localparam int unsigned S_DATA_W = 80;
	localparam int unsigned M_DATA_W = 40;

	localparam int unsigned YP_W     = 15;
	localparam int unsigned YT_W     = 16;
	localparam int unsigned Q_W      = 9;
	localparam int unsigned PROD_W   = 30;
	localparam int unsigned CUMD_W   = 9;
	localparam int unsigned DN_W     = 23;
	localparam int unsigned CNT_W    = 20;
	localparam int unsigned DAYS_W   = 24;
	localparam int unsigned HRS_W    = 29;
	localparam int unsigned MINS_W   = 35;
	localparam int unsigned SECS_W   = 41;
	localparam int unsigned HDIFF_W  = 6;
	localparam int unsigned MSDIFF_W = 7;

	localparam int unsigned RECIP_SHIFT = 21;
	localparam logic [YP_W-1:0] RECIP_MUL   = 15'd20972;
	localparam logic [YP_W-1:0] YEAR_BIAS   = 15'd399;
	localparam logic [9:0]      DAYS_PER_YEAR = 10'd365;
	localparam logic [6:0]      CENTURY     = 7'd100;
	localparam logic [MON_W-1:0] LAST_MONTH = 4'd12;

	localparam logic signed [4:0] MONTHS_PER_YEAR = 5'sd12;
	localparam logic signed [5:0] HOURS_PER_DAY   = 6'sd24;
	localparam logic signed [6:0] MINS_PER_HOUR   = 7'sd60;
	localparam logic signed [6:0] SECS_PER_MIN    = 7'sd60;

	typedef enum logic [CMD_W-1:0] {
		UNIT_YEARS   = 3'd0,
		UNIT_MONTHS  = 3'd1,
		UNIT_DAYS    = 3'd2,
		UNIT_HOURS   = 3'd3,
		UNIT_MINUTES = 3'd4,
		UNIT_SECONDS = 3'd5
	} unit_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [YEAR_W-1:0]  birth_year;
		logic [MON_W-1:0]   birth_month;
		logic [DAY_W-1:0]   birth_day;
		logic [CLOCK_W-1:0] birth_clock;
		logic [YEAR_W-1:0]  ref_year;
		logic [MON_W-1:0]   ref_month;
		logic [DAY_W-1:0]   ref_day;
		logic [CLOCK_W-1:0] ref_clock;
	} query_t;

	typedef struct packed {
		logic [CMD_W-1:0]           cmd;
		logic [DN_W-1:0]            dn_birth;
		logic [DN_W-1:0]            dn_ref;
		logic signed [CNT_W-1:0]    cal_cnt;
		logic signed [HDIFF_W-1:0]  hour_diff;
		logic signed [MSDIFF_W-1:0] min_diff;
		logic signed [MSDIFF_W-1:0] sec_diff;
	} date_res_t;

	typedef struct packed {
		logic             ydec;
		logic             yinc;
		logic [MON_W-1:0] mon;
	} mwrap_t;

	// Month zero is December of the previous year, months past twelve run
	// into the next year.
	function automatic mwrap_t month_wrap(input logic [MON_W-1:0] m);
		mwrap_t w;
		w.ydec = 1'b0;
		w.yinc = 1'b0;
		w.mon  = m;
		if (m == '0) begin
			w.ydec = 1'b1;
			w.mon  = LAST_MONTH;
		end else if (m > LAST_MONTH) begin
			w.yinc = 1'b1;
			w.mon  = m - LAST_MONTH;
		end
		return w;
	endfunction

	// Days from the first of March to the first of the given raw month.
	function automatic logic [CUMD_W-1:0] march_cum(input logic [MON_W-1:0] m);
		logic [CUMD_W-1:0] r;
		case (m)
			4'd0:    r = 9'd275;
			4'd1:    r = 9'd306;
			4'd2:    r = 9'd337;
			4'd4:    r = 9'd31;
			4'd5:    r = 9'd61;
			4'd6:    r = 9'd92;
			4'd7:    r = 9'd122;
			4'd8:    r = 9'd153;
			4'd9:    r = 9'd184;
			4'd10:   r = 9'd214;
			4'd11:   r = 9'd245;
			4'd12:   r = 9'd275;
			4'd13:   r = 9'd306;
			4'd14:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Offset of the March-based year, added on top of the year bias.
	function automatic logic [1:0] march_yoff(input logic [MON_W-1:0] m);
		logic [1:0] r;
		if (m inside {[4'd0:4'd2]}) begin
			r = 2'd0;
		end else if (m == 4'd15) begin
			r = 2'd2;
		end else begin
			r = 2'd1;
		end
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] r;
		case (m)
			4'd2:                    r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default:                 r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

@@ sv/cac_date.sv @@
// Date stages of the calendar age calculator: day numbers of both dates and
// the whole-year or whole-month count. Depends on cac_pkg.
module cac_date (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cac_pkg::query_t     in_query,
	output logic                out_valid,
	input  logic                out_ready,
	output cac_pkg::date_res_t  out_res
);

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	logic [cac_pkg::MON_W-1:0]            tgt_mon;
	cac_pkg::mwrap_t                      wrap;
	logic signed [cac_pkg::YT_W-1:0]      yt_in;
	logic [cac_pkg::YP_W-1:0]             ypb_in, ypr_in;
	logic [cac_pkg::CUMD_W-1:0]           cumdb_in, cumdr_in;
	logic signed [cac_pkg::YEAR_W:0]      ydiff_in;
	logic signed [cac_pkg::MON_W:0]       mdiff_in;
	logic signed [cac_pkg::CNT_W-1:0]     ydiff_ext, cnt_in;
	logic signed [cac_pkg::HDIFF_W-1:0]   hdiff_in;
	logic signed [cac_pkg::MSDIFF_W-1:0]  mdiff_clk_in, sdiff_in;

	logic [cac_pkg::CMD_W-1:0]            cmd_s1, cmd_s2;
	logic [cac_pkg::YP_W-1:0]             ypb_s1, ypr_s1, ypb_s2, ypr_s2;
	logic [cac_pkg::CUMD_W-1:0]           cumdb_s1, cumdr_s1;
	logic signed [cac_pkg::YT_W-1:0]      yt_s1, yt_s2;
	logic [cac_pkg::MON_W-1:0]            mt_s1, mt_s2, rm_s1, rm_s2;
	logic [cac_pkg::DAY_W-1:0]            bd_s1, bd_s2, rd_s1, rd_s2;
	logic [cac_pkg::YEAR_W-1:0]           ry_s1, ry_s2;
	logic signed [cac_pkg::CNT_W-1:0]     cnt_s1, cnt_s2;
	logic signed [cac_pkg::HDIFF_W-1:0]   hdiff_s1, hdiff_s2;
	logic signed [cac_pkg::MSDIFF_W-1:0]  mdiff_s1, mdiff_s2, sdiff_s1, sdiff_s2;

	logic [cac_pkg::PROD_W-1:0]           prod_b, prod_r, prod_t;
	logic [cac_pkg::DN_W-1:0]             ab_in, ar_in;
	logic [cac_pkg::Q_W-1:0]              qb_s2, qr_s2, qt_s2;
	logic [cac_pkg::DN_W-1:0]             ab_s2, ar_s2;

	logic [cac_pkg::DN_W-1:0]             dnb_in, dnr_in;
	logic [cac_pkg::YT_W-1:0]             qt100;
	logic                                 leap;
	logic [cac_pkg::DAY_W-1:0]            mlen, dcl;
	logic signed [cac_pkg::YT_W-1:0]      ry_ext;
	logic                                 after;
	cac_pkg::date_res_t                   res_in, res_s3;

	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		tgt_mon = (in_query.cmd == cac_pkg::UNIT_YEARS) ? in_query.birth_month
			: in_query.ref_month;
		wrap = cac_pkg::month_wrap(tgt_mon);
		yt_in = cac_pkg::YT_W'(in_query.ref_year) + cac_pkg::YT_W'(wrap.yinc)
			- cac_pkg::YT_W'(wrap.ydec);
		ypb_in = cac_pkg::YP_W'(in_query.birth_year) + cac_pkg::YEAR_BIAS
			+ cac_pkg::YP_W'(cac_pkg::march_yoff(in_query.birth_month));
		ypr_in = cac_pkg::YP_W'(in_query.ref_year) + cac_pkg::YEAR_BIAS
			+ cac_pkg::YP_W'(cac_pkg::march_yoff(in_query.ref_month));
		cumdb_in = cac_pkg::march_cum(in_query.birth_month)
			+ cac_pkg::CUMD_W'(in_query.birth_day);
		cumdr_in = cac_pkg::march_cum(in_query.ref_month)
			+ cac_pkg::CUMD_W'(in_query.ref_day);
		ydiff_in = $signed({1'b0, in_query.ref_year}) - $signed({1'b0, in_query.birth_year});
		mdiff_in = $signed({1'b0, in_query.ref_month}) - $signed({1'b0, in_query.birth_month});
		ydiff_ext = cac_pkg::CNT_W'(ydiff_in);
		if (in_query.cmd == cac_pkg::UNIT_YEARS) begin
			cnt_in = ydiff_ext;
		end else begin
			cnt_in = ydiff_ext * cac_pkg::CNT_W'(cac_pkg::MONTHS_PER_YEAR)
				+ cac_pkg::CNT_W'(mdiff_in);
		end
		hdiff_in = $signed({1'b0, in_query.ref_clock[16:12]})
			- $signed({1'b0, in_query.birth_clock[16:12]});
		mdiff_clk_in = $signed({1'b0, in_query.ref_clock[11:6]})
			- $signed({1'b0, in_query.birth_clock[11:6]});
		sdiff_in = $signed({1'b0, in_query.ref_clock[5:0]})
			- $signed({1'b0, in_query.birth_clock[5:0]});
	end

	always_comb begin
		prod_b = cac_pkg::PROD_W'(ypb_s1) * cac_pkg::PROD_W'(cac_pkg::RECIP_MUL);
		prod_r = cac_pkg::PROD_W'(ypr_s1) * cac_pkg::PROD_W'(cac_pkg::RECIP_MUL);
		prod_t = cac_pkg::PROD_W'(yt_s1[cac_pkg::YP_W-1:0])
			* cac_pkg::PROD_W'(cac_pkg::RECIP_MUL);
		ab_in = cac_pkg::DN_W'(ypb_s1) * cac_pkg::DN_W'(cac_pkg::DAYS_PER_YEAR)
			+ cac_pkg::DN_W'(cumdb_s1);
		ar_in = cac_pkg::DN_W'(ypr_s1) * cac_pkg::DN_W'(cac_pkg::DAYS_PER_YEAR)
			+ cac_pkg::DN_W'(cumdr_s1);
	end

	always_comb begin
		dnb_in = ab_s2 + cac_pkg::DN_W'(ypb_s2[cac_pkg::YP_W-1:2])
			- cac_pkg::DN_W'(qb_s2) + cac_pkg::DN_W'(qb_s2[cac_pkg::Q_W-1:2]);
		dnr_in = ar_s2 + cac_pkg::DN_W'(ypr_s2[cac_pkg::YP_W-1:2])
			- cac_pkg::DN_W'(qr_s2) + cac_pkg::DN_W'(qr_s2[cac_pkg::Q_W-1:2]);
		qt100 = cac_pkg::YT_W'(qt_s2) * cac_pkg::YT_W'(cac_pkg::CENTURY);
		leap = (yt_s2[1:0] == 2'b00)
			&& ((qt100 != $unsigned(yt_s2)) || (qt_s2[1:0] == 2'b00));
		mlen = cac_pkg::month_len(mt_s2, leap);
		dcl = (bd_s2 < mlen) ? bd_s2 : mlen;
		ry_ext = $signed(cac_pkg::YT_W'(ry_s2));
		if (yt_s2 != ry_ext) begin
			after = yt_s2 > ry_ext;
		end else if (mt_s2 != rm_s2) begin
			after = mt_s2 > rm_s2;
		end else begin
			after = dcl > rd_s2;
		end
		res_in.cmd       = cmd_s2;
		res_in.dn_birth  = dnb_in;
		res_in.dn_ref    = dnr_in;
		res_in.cal_cnt   = cnt_s2 - $signed(cac_pkg::CNT_W'(after));
		res_in.hour_diff = hdiff_s2;
		res_in.min_diff  = mdiff_s2;
		res_in.sec_diff  = sdiff_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1   <= in_query.cmd;
			ypb_s1   <= ypb_in;
			ypr_s1   <= ypr_in;
			cumdb_s1 <= cumdb_in;
			cumdr_s1 <= cumdr_in;
			yt_s1    <= yt_in;
			mt_s1    <= wrap.mon;
			bd_s1    <= in_query.birth_day;
			ry_s1    <= in_query.ref_year;
			rm_s1    <= in_query.ref_month;
			rd_s1    <= in_query.ref_day;
			cnt_s1   <= cnt_in;
			hdiff_s1 <= hdiff_in;
			mdiff_s1 <= mdiff_clk_in;
			sdiff_s1 <= sdiff_in;
		end
		if (adv2) begin
			cmd_s2   <= cmd_s1;
			qb_s2    <= prod_b[cac_pkg::RECIP_SHIFT +: cac_pkg::Q_W];
			qr_s2    <= prod_r[cac_pkg::RECIP_SHIFT +: cac_pkg::Q_W];
			qt_s2    <= prod_t[cac_pkg::RECIP_SHIFT +: cac_pkg::Q_W];
			ab_s2    <= ab_in;
			ar_s2    <= ar_in;
			ypb_s2   <= ypb_s1;
			ypr_s2   <= ypr_s1;
			yt_s2    <= yt_s1;
			mt_s2    <= mt_s1;
			bd_s2    <= bd_s1;
			ry_s2    <= ry_s1;
			rm_s2    <= rm_s1;
			rd_s2    <= rd_s1;
			cnt_s2   <= cnt_s1;
			hdiff_s2 <= hdiff_s1;
			mdiff_s2 <= mdiff_s1;
			sdiff_s2 <= sdiff_s1;
		end
		if (adv3) begin
			res_s3 <= res_in;
		end
	end

	assign out_valid = v_s3;
	assign out_res   = res_s3;

endmodule

@@ sv/cac_time.sv @@
// Time stages of the calendar age calculator: day difference, then hours,
// minutes and seconds, and the output register. Depends on cac_pkg.
module cac_time (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  cac_pkg::date_res_t                  in_res,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cac_pkg::AGE_W-1:0]           out_age,
	output logic                                out_ok
);

	logic v_s4, v_s5, v_s6, v_s7;
	logic adv4, adv5, adv6, adv7;

	logic signed [cac_pkg::DAYS_W-1:0]    days_in, val_in4, val_s4;
	logic                                 ok_in4, ok_s4;
	logic signed [cac_pkg::HRS_W-1:0]     hrs, val_in5, val_s5;
	logic                                 ok_in5, ok_s5;
	logic signed [cac_pkg::MINS_W-1:0]    mins, val_in6, val_s6;
	logic                                 ok_in6, ok_s6;
	logic signed [cac_pkg::SECS_W-1:0]    secs, val_in7;
	logic                                 ok_in7, ok_s7;
	logic [cac_pkg::AGE_W-1:0]            age_s7;

	logic [cac_pkg::CMD_W-1:0]            cmd_s4, cmd_s5, cmd_s6;
	logic signed [cac_pkg::HDIFF_W-1:0]   hdiff_s4;
	logic signed [cac_pkg::MSDIFF_W-1:0]  mdiff_s4, mdiff_s5, sdiff_s4, sdiff_s5, sdiff_s6;

	assign adv7     = !v_s7 || out_ready;
	assign adv6     = !v_s6 || adv7;
	assign adv5     = !v_s5 || adv6;
	assign adv4     = !v_s4 || adv5;
	assign in_ready = adv4;

	always_comb begin
		days_in = $signed({1'b0, in_res.dn_ref}) - $signed({1'b0, in_res.dn_birth});
		val_in4 = days_in;
		ok_in4  = 1'b0;
		if (in_res.cmd inside {cac_pkg::UNIT_YEARS, cac_pkg::UNIT_MONTHS}) begin
			val_in4 = cac_pkg::DAYS_W'(in_res.cal_cnt);
			ok_in4  = !in_res.cal_cnt[cac_pkg::CNT_W-1];
		end else if (in_res.cmd inside {cac_pkg::UNIT_DAYS, cac_pkg::UNIT_HOURS,
				cac_pkg::UNIT_MINUTES, cac_pkg::UNIT_SECONDS}) begin
			ok_in4 = !days_in[cac_pkg::DAYS_W-1];
		end
	end

	always_comb begin
		hrs = cac_pkg::HRS_W'(val_s4) * cac_pkg::HRS_W'(cac_pkg::HOURS_PER_DAY)
			+ cac_pkg::HRS_W'(hdiff_s4);
		val_in5 = cac_pkg::HRS_W'(val_s4);
		ok_in5  = ok_s4;
		if (ok_s4 && (cmd_s4 inside {cac_pkg::UNIT_HOURS, cac_pkg::UNIT_MINUTES,
				cac_pkg::UNIT_SECONDS})) begin
			val_in5 = hrs;
			ok_in5  = !hrs[cac_pkg::HRS_W-1];
		end
	end

	always_comb begin
		mins = cac_pkg::MINS_W'(val_s5) * cac_pkg::MINS_W'(cac_pkg::MINS_PER_HOUR)
			+ cac_pkg::MINS_W'(mdiff_s5);
		val_in6 = cac_pkg::MINS_W'(val_s5);
		ok_in6  = ok_s5;
		if (ok_s5 && (cmd_s5 inside {cac_pkg::UNIT_MINUTES, cac_pkg::UNIT_SECONDS})) begin
			val_in6 = mins;
			ok_in6  = !mins[cac_pkg::MINS_W-1];
		end
	end

	always_comb begin
		secs = cac_pkg::SECS_W'(val_s6) * cac_pkg::SECS_W'(cac_pkg::SECS_PER_MIN)
			+ cac_pkg::SECS_W'(sdiff_s6);
		val_in7 = cac_pkg::SECS_W'(val_s6);
		ok_in7  = ok_s6;
		if (ok_s6 && (cmd_s6 == cac_pkg::UNIT_SECONDS)) begin
			val_in7 = secs;
			ok_in7  = !secs[cac_pkg::SECS_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv4) begin
				v_s4 <= in_valid;
			end
			if (adv5) begin
				v_s5 <= v_s4;
			end
			if (adv6) begin
				v_s6 <= v_s5;
			end
			if (adv7) begin
				v_s7 <= v_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			cmd_s4   <= in_res.cmd;
			val_s4   <= val_in4;
			ok_s4    <= ok_in4;
			hdiff_s4 <= in_res.hour_diff;
			mdiff_s4 <= in_res.min_diff;
			sdiff_s4 <= in_res.sec_diff;
		end
		if (adv5) begin
			cmd_s5   <= cmd_s4;
			val_s5   <= val_in5;
			ok_s5    <= ok_in5;
			mdiff_s5 <= mdiff_s4;
			sdiff_s5 <= sdiff_s4;
		end
		if (adv6) begin
			cmd_s6   <= cmd_s5;
			val_s6   <= val_in6;
			ok_s6    <= ok_in6;
			sdiff_s6 <= sdiff_s5;
		end
		if (adv7) begin
			age_s7 <= ok_in7 ? val_in7[cac_pkg::AGE_W-1:0] : '0;
			ok_s7  <= ok_in7;
		end
	end

	assign out_valid = v_s7;
	assign out_age   = age_s7;
	assign out_ok    = ok_s7;

`ifndef NO_ASSERTIONS
	a_stall_holds_s6: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && !out_ready && v_s6 |=> v_s6 && $stable(val_s6) && $stable(ok_s6))
		else $error("stage 6 word changed while the output was stalled");

	a_hours_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && ok_s5 |-> !val_s5[cac_pkg::HRS_W-1])
		else $error("valid age went negative after the hours step");

	a_unknown_unit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && (cmd_s4 > cac_pkg::UNIT_SECONDS) |-> !ok_s4)
		else $error("unknown unit marked valid");
`endif

endmodule

@@ sv/calendar_age_calculator.sv @@
// Calendar age calculator, top level. Depends on cac_pkg, cac_date, cac_time.
// A query word enters on the slave side: s_tuser carries the unit, s_tdata
// the birth and reference date-times. The completed age leaves on the master
// side: m_tdata carries the age, m_tuser is set when the age is valid
// (non-negative); an invalid age is reported as zero.
// Every accepted word yields exactly one result word, in order.
// The result passes through seven register stages: year prep, reciprocal
// multiply for the century split, day numbers and the calendar compare, day
// difference, then one stage each for hours, minutes and seconds. One word can
// be accepted every cycle while the output is not stalled.
// Each stage holds its own valid bit, so when the receiver drops m_tready
// the pipeline keeps filling its empty stages and s_tready falls only when
// every stage holds a word. Nothing is lost or repeated under a stall.
// Reset clears all valid bits; the block is ready for a word right after.
module calendar_age_calculator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// birth_year, birth_month, birth_day, birth_clock, ref_year, ref_month,
	// ref_day, ref_clock
	input  logic [cac_pkg::S_DATA_W-1:0]      s_tdata,
	// cmd
	input  logic [cac_pkg::CMD_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// age_value, then zero padding
	output logic [cac_pkg::M_DATA_W-1:0]      m_tdata,
	// age_valid
	output logic                              m_tuser
);

	cac_pkg::query_t             query;
	cac_pkg::date_res_t          date_res;
	logic                        date_valid, date_ready;
	logic [cac_pkg::AGE_W-1:0]   age;

	assign query.cmd         = s_tuser;
	assign query.birth_year  = s_tdata[13:0];
	assign query.birth_month = s_tdata[17:14];
	assign query.birth_day   = s_tdata[22:18];
	assign query.birth_clock = s_tdata[39:23];
	assign query.ref_year    = s_tdata[53:40];
	assign query.ref_month   = s_tdata[57:54];
	assign query.ref_day     = s_tdata[62:58];
	assign query.ref_clock   = s_tdata[79:63];

	cac_date u_date (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_query  (query),
		.out_valid (date_valid),
		.out_ready (date_ready),
		.out_res   (date_res)
	);

	cac_time u_time (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (date_valid),
		.in_ready  (date_ready),
		.in_res    (date_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_age   (age),
		.out_ok    (m_tuser)
	);

	assign m_tdata = {{(cac_pkg::M_DATA_W - cac_pkg::AGE_W){1'b0}}, age};

`ifndef NO_ASSERTIONS
	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("invalid age word carries a nonzero value");

	a_backpressure_source: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while the output was not blocked");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for calendar_age_calculator: streams date-time queries
// through the block and compares every age word with a calendar predictor.
// Depends on cac_pkg and the calendar_age_calculator RTL.
module tb;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS   = 185;
	localparam logic [cac_pkg::CMD_W-1:0] UNIT_SPARE_LO = 3'd6;
	localparam logic [cac_pkg::CMD_W-1:0] UNIT_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [cac_pkg::AGE_W-1:0] value;
		logic                      valid;
	} age_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [cac_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic [cac_pkg::CMD_W-1:0]    s_tuser = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [cac_pkg::M_DATA_W-1:0] m_tdata;
	logic                         m_tuser;

	cac_pkg::query_t feed_q[$];
	age_t            age_q[$];
	cac_pkg::query_t cur_query = '0;
	logic    s_fire = 1'b0;
	int      idle_pct = 0;
	int      stall_pct = 0;
	int      hold_req = 0;
	int      hold_done = 0;
	int      hold_left = 0;
	int      mismatches = 0;
	int      results_seen = 0;
	int      cycle_count = 0;

	calendar_age_calculator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit is_leap(input longint y);
		return (y % 4 == 0) && (y % 100 != 0 || y % 400 == 0);
	endfunction

	function automatic longint month_days(input longint y, input longint m);
		if (m == 2) return is_leap(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
		return 31;
	endfunction

	function automatic void split_month_index(input longint idx, output longint y,
			output longint m);
		y = idx / 12;
		m = idx % 12;
		if (m < 0) begin
			m += 12;
			y--;
		end
		m++;
	endfunction

	function automatic longint gregorian_day(input longint y, input longint m,
			input longint d);
		longint yy, mm, era, yoe, doy;
		split_month_index(y * 12 + m - 1, yy, mm);
		if (mm <= 2) yy--;
		era = (yy >= 0 ? yy : yy - 399) / 400;
		yoe = yy - era * 400;
		doy = (153 * (mm > 2 ? mm - 3 : mm + 9) + 2) / 5 + d - 1;
		return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
	endfunction

	function automatic bit lands_after(input longint by, input longint bm,
			input longint bd, input longint n, input longint ry, input longint rm,
			input longint rd);
		longint y, m, len, d;
		split_month_index(by * 12 + bm - 1 + n, y, m);
		len = month_days(y, m);
		d = bd < len ? bd : len;
		if (y != ry) return y > ry;
		if (m != rm) return m > rm;
		return d > rd;
	endfunction

	function automatic age_t predict_age(input cac_pkg::query_t q);
		longint by, bm, bd, ry, rm, rd, bh, bmi, bs, rh, rmi, rs, n, v;
		bit ok;
		age_t r;
		by = longint'(q.birth_year);
		bm = longint'(q.birth_month);
		bd = longint'(q.birth_day);
		ry = longint'(q.ref_year);
		rm = longint'(q.ref_month);
		rd = longint'(q.ref_day);
		bh = longint'(q.birth_clock[16:12]);
		bmi = longint'(q.birth_clock[11:6]);
		bs = longint'(q.birth_clock[5:0]);
		rh = longint'(q.ref_clock[16:12]);
		rmi = longint'(q.ref_clock[11:6]);
		rs = longint'(q.ref_clock[5:0]);
		v = 0;
		ok = 1'b0;
		if (q.cmd == cac_pkg::UNIT_YEARS || q.cmd == cac_pkg::UNIT_MONTHS) begin
			n = (ry - by) * 12;
			if (q.cmd == cac_pkg::UNIT_MONTHS) n += rm - bm;
			v = (q.cmd == cac_pkg::UNIT_YEARS) ? ry - by : n;
			if (lands_after(by, bm, bd, n, ry, rm, rd)) v--;
			ok = v >= 0;
		end else if (q.cmd <= cac_pkg::UNIT_SECONDS) begin
			v = gregorian_day(ry, rm, rd) - gregorian_day(by, bm, bd);
			ok = v >= 0;
			if (ok && q.cmd >= cac_pkg::UNIT_HOURS) begin
				v = v * 24 + (rh - bh);
				ok = v >= 0;
			end
			if (ok && q.cmd >= cac_pkg::UNIT_MINUTES) begin
				v = v * 60 + (rmi - bmi);
				ok = v >= 0;
			end
			if (ok && q.cmd >= cac_pkg::UNIT_SECONDS) begin
				v = v * 60 + (rs - bs);
				ok = v >= 0;
			end
		end
		r.valid = ok;
		r.value = ok ? v[cac_pkg::AGE_W-1:0] : '0;
		return r;
	endfunction

	function automatic logic [cac_pkg::CLOCK_W-1:0] hms(input int h, input int m,
			input int s);
		return {h[4:0], m[5:0], s[5:0]};
	endfunction

	function automatic cac_pkg::query_t make_query(input logic [cac_pkg::CMD_W-1:0] cmd,
			input int by, input int bm, input int bd, input int bc, input int ry,
			input int rm, input int rd, input int rc);
		cac_pkg::query_t q;
		q.cmd = cmd;
		q.birth_year = by[cac_pkg::YEAR_W-1:0];
		q.birth_month = bm[cac_pkg::MON_W-1:0];
		q.birth_day = bd[cac_pkg::DAY_W-1:0];
		q.birth_clock = bc[cac_pkg::CLOCK_W-1:0];
		q.ref_year = ry[cac_pkg::YEAR_W-1:0];
		q.ref_month = rm[cac_pkg::MON_W-1:0];
		q.ref_day = rd[cac_pkg::DAY_W-1:0];
		q.ref_clock = rc[cac_pkg::CLOCK_W-1:0];
		return q;
	endfunction

	function automatic int pick_day(input int y, input int m);
		int len;
		len = int'(month_days(y, m));
		if ($urandom_range(0, 1) == 0) return len - int'($urandom_range(0, 2));
		return int'($urandom_range(1, len));
	endfunction

	function automatic logic [cac_pkg::CLOCK_W-1:0] random_clock();
		return hms($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
	endfunction

	function automatic cac_pkg::query_t random_query();
		cac_pkg::query_t q;
		int by, bm, bd, ry, rm, rd;
		if ($urandom_range(0, 99) < 12) begin
			return make_query(cac_pkg::CMD_W'($urandom_range(0, 7)),
				$urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
				$urandom_range(0, 131071), $urandom_range(0, 16383),
				$urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 131071));
		end
		by = $urandom_range(1, 9999);
		bm = $urandom_range(1, 12);
		bd = pick_day(by, bm);
		case ($urandom_range(0, 2))
			0: begin
				ry = $urandom_range(1, 9999);
				rm = $urandom_range(1, 12);
				rd = pick_day(ry, rm);
			end
			1: begin
				ry = by + int'($urandom_range(0, 3)) - 1;
				rm = $urandom_range(1, 12);
				rd = pick_day(ry, rm);
			end
			default: begin
				ry = by;
				rm = bm;
				rd = bd + int'($urandom_range(0, 2)) - 1;
				if (rd > 31) rd = 31;
			end
		endcase
		q = make_query(cac_pkg::CMD_W'($urandom_range(0, 5)), by, bm, bd, random_clock(),
			ry, rm, rd, random_clock());
		if ($urandom_range(0, 2) == 0) begin
			q.ref_clock = q.birth_clock;
			case ($urandom_range(0, 2))
				0: q.ref_clock[16:12] = 5'($urandom_range(0, 23));
				1: q.ref_clock[11:6] = 6'($urandom_range(0, 59));
				default: q.ref_clock[5:0] = 6'($urandom_range(0, 59));
			endcase
		end
		return q;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 40) begin
			$display("mismatch at word %0d: %s, got %0h, expected %0h", results_seen, what,
				got, want);
		end
		mismatches++;
	endtask

	task automatic wait_drained();
		while (feed_q.size() != 0 || s_tvalid || age_q.size() != 0) @(posedge clk);
	endtask

	always @(negedge clk) begin : drive_proc
		cac_pkg::query_t item;
		if (arst_n && (!s_tvalid || s_fire)) begin
			if (feed_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				item = feed_q.pop_front();
				cur_query <= item;
				s_tdata <= {item.ref_clock, item.ref_day, item.ref_month, item.ref_year,
					item.birth_clock, item.birth_day, item.birth_month, item.birth_year};
				s_tuser <= item.cmd;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req != hold_done) begin
			hold_done <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : watch_proc
		age_t want;
		s_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (age_q.size() == 0) begin
					report_mismatch("word with none expected", 64'(m_tdata), 64'd0);
				end else begin
					want = age_q.pop_front();
					if (m_tdata[cac_pkg::AGE_W-1:0] !== want.value)
						report_mismatch("age_value", 64'(m_tdata[cac_pkg::AGE_W-1:0]),
							64'(want.value));
					if (m_tuser !== want.valid)
						report_mismatch("age_valid", 64'(m_tuser), 64'(want.valid));
					if (m_tdata[cac_pkg::M_DATA_W-1:cac_pkg::AGE_W] !== '0)
						report_mismatch("padding",
							64'(m_tdata[cac_pkg::M_DATA_W-1:cac_pkg::AGE_W]), 64'd0);
				end
				results_seen++;
			end
			if (s_tvalid && s_tready) age_q.push_back(predict_age(cur_query));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		int phase;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		feed_q.push_back(make_query(cac_pkg::UNIT_YEARS, 2000, 2, 29, 0, 2001, 2, 28, 0));
		feed_q.push_back(make_query(cac_pkg::UNIT_YEARS, 2000, 2, 29, 0, 2004, 2, 28, 0));
		feed_q.push_back(make_query(cac_pkg::UNIT_YEARS, 2010, 5, 10, 0, 2010, 5, 9, 0));
		feed_q.push_back(make_query(cac_pkg::UNIT_YEARS, 0, 0, 0, 0, 16383, 15, 31,
			'h1FFFF));
		feed_q.push_back(make_query(cac_pkg::UNIT_MONTHS, 2023, 1, 31, 0, 2023, 2, 28, 0));
		feed_q.push_back(make_query(cac_pkg::UNIT_MONTHS, 2023, 3, 31, 0, 2023, 4, 29, 0));
		feed_q.push_back(make_query(cac_pkg::UNIT_MONTHS, 2020, 0, 0, 0, 2021, 13, 0, 0));
		feed_q.push_back(make_query(cac_pkg::UNIT_MONTHS, 2020, 15, 31, 0, 2020, 14, 5, 0));
		feed_q.push_back(make_query(cac_pkg::UNIT_MONTHS, 16383, 15, 31, 0, 16383, 15, 31,
			0));
		feed_q.push_back(make_query(cac_pkg::UNIT_DAYS, 1, 1, 1, 0, 9999, 12, 31, 0));
		feed_q.push_back(make_query(cac_pkg::UNIT_DAYS, 0, 2, 29, 0, 1, 3, 1, 0));
		feed_q.push_back(make_query(cac_pkg::UNIT_DAYS, 2019, 0, 0, 0, 2019, 15, 31, 0));
		feed_q.push_back(make_query(cac_pkg::UNIT_DAYS, 16383, 15, 31, 'h1FFFF, 0, 0, 0,
			0));
		feed_q.push_back(make_query(cac_pkg::UNIT_HOURS, 2024, 6, 1, hms(10, 0, 0), 2024,
			6, 1, hms(9, 59, 59)));
		feed_q.push_back(make_query(cac_pkg::UNIT_HOURS, 2024, 6, 1, hms(23, 0, 0), 2024,
			6, 2, hms(1, 0, 0)));
		feed_q.push_back(make_query(cac_pkg::UNIT_MINUTES, 2024, 6, 1, hms(10, 30, 0),
			2024, 6, 1, hms(10, 29, 0)));
		feed_q.push_back(make_query(cac_pkg::UNIT_MINUTES, 2024, 6, 1, hms(31, 63, 0),
			2024, 6, 2, hms(0, 0, 0)));
		feed_q.push_back(make_query(cac_pkg::UNIT_SECONDS, 2024, 6, 1, hms(10, 30, 20),
			2024, 6, 1, hms(10, 30, 19)));
		feed_q.push_back(make_query(cac_pkg::UNIT_SECONDS, 2024, 6, 1, hms(12, 0, 0),
			2024, 6, 1, hms(12, 0, 0)));
		feed_q.push_back(make_query(cac_pkg::UNIT_SECONDS, 0, 0, 0, 0, 16383, 15, 31,
			'h1FFFF));
		feed_q.push_back(make_query(UNIT_SPARE_LO, 1990, 1, 1, 0, 2020, 1, 1, 0));
		feed_q.push_back(make_query(UNIT_SPARE_HI, 1990, 1, 1, 0, 2020, 1, 1, 0));
		wait_drained();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
					hold_req++;
				end
				1: begin
					idle_pct = 71;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 71;
				end
				default: begin
					idle_pct = 30;
					stall_pct = 30;
				end
			endcase
			repeat (PHASE_ITEMS) feed_q.push_back(random_query());
			wait_drained();
		end

		idle_pct = 0;
		stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (age_q.size() != 0)
			report_mismatch("words never delivered", 64'(age_q.size()), 64'd0);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/cac_pkg.sv
sv/cac_date.sv
sv/cac_time.sv
sv/calendar_age_calculator.sv
tb/tb.sv
